// File: hdl/hcmw_pkg.sv
// Shared types and constants for the hex command line memory writer.
`timescale 1ns / 1ps

package hcmw_pkg;

  localparam int LINE_MAX     = 7;
  localparam int STORE_DEPTH  = 1024;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int LINE_CW      = $clog2(LINE_MAX + 1);

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_ADDR_FMT  = 3'd2,
    ST_ADDR_HIGH = 3'd3,
    ST_BYTE_FMT  = 3'd4
  } status_t;

  // What the back end has to do with a closed line.
  typedef enum logic [1:0] {
    CMD_ADDR_FMT,
    CMD_ADDR_HIGH,
    CMD_BYTE_FMT,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
  } cmd_t;

endpackage

// File: hdl/hcmw_front.sv
// Line editor and parser: collects characters and classifies each closed line.
`timescale 1ns / 1ps

module hcmw_front
  import hcmw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_char[7:0]
  input  logic       clearing,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0]         line_chars [LINE_MAX];
  logic [LINE_CW-1:0] char_count;

  logic       accept;
  logic       is_eol;
  logic       is_del;
  logic [4:0] c_hex;
  logic [4:0] d_hex [4];
  logic [4:0] hi_hex;
  logic [4:0] lo_hex;
  logic       addr_ok;
  logic [15:0] addr;

  // Bit 4 flags a hex digit (0-9 or lowercase a-f), bits 3:0 carry its value.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  assign s_tready = !clearing && !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
  assign is_del   = (s_tdata == CH_BS) || (s_tdata == CH_DEL);
  assign c_hex    = hex_of(s_tdata);
  assign push     = accept && is_eol;

  // Unfilled positions hold zero, since deletes and line closes clear them.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      d_hex[k] = hex_of(line_chars[k]);
    end
    hi_hex  = hex_of(line_chars[5]);
    lo_hex  = hex_of(line_chars[6]);
    addr_ok = d_hex[0][4] && d_hex[1][4] && d_hex[2][4] && d_hex[3][4] &&
              (line_chars[4] == CH_SPACE);
    addr    = {d_hex[0][3:0], d_hex[1][3:0], d_hex[2][3:0], d_hex[3][3:0]};

    push_cmd.kind      = CMD_LOOKUP;
    push_cmd.address   = addr;
    push_cmd.data_byte = {hi_hex[3:0], lo_hex[3:0]};
    if (!addr_ok) begin
      push_cmd.kind      = CMD_ADDR_FMT;
      push_cmd.address   = 16'd0;
      push_cmd.data_byte = 8'd0;
    end else if ({1'b0, addr} >= 17'(STORE_DEPTH)) begin
      push_cmd.kind      = CMD_ADDR_HIGH;
      push_cmd.data_byte = 8'd0;
    end else if (!hi_hex[4] || !lo_hex[4]) begin
      push_cmd.kind      = CMD_BYTE_FMT;
      push_cmd.data_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      for (int k = 0; k < LINE_MAX; k++) begin
        line_chars[k] <= 8'd0;
      end
    end else if (accept) begin
      if (is_eol) begin
        char_count <= '0;
        for (int k = 0; k < LINE_MAX; k++) begin
          line_chars[k] <= 8'd0;
        end
      end else if (is_del) begin
        if (char_count != '0) begin
          char_count <= char_count - 1'b1;
          line_chars[char_count - 1'b1] <= 8'd0;
        end
      end else if ((s_tdata == CH_SPACE) || c_hex[4]) begin
        if (char_count < LINE_CW'(LINE_MAX)) begin
          line_chars[char_count] <= s_tdata;
          char_count <= char_count + 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/hcmw_queue.sv
// Short command queue between the line parser and the store back end.
`timescale 1ns / 1ps

module hcmw_queue
  import hcmw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full  = (fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hdl/hcmw_back.sv
// Back end: byte store with erase sweep, compare-and-write and result register.
`timescale 1ns / 1ps

module hcmw_back
  import hcmw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        clearing,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[2:0], address[18:3], data_byte[26:19]
);

  logic [7:0]          byte_store [STORE_DEPTH];
  logic [STORE_AW-1:0] clr_idx;
  logic [7:0]          rd_byte;

  logic       a_valid;
  cmd_t       a_cmd;
  logic       a_fwd;
  logic [7:0] a_fwd_byte;
  logic       a_adv;
  logic [7:0] stored;
  logic       same;
  logic       wr_en;
  logic       fwd_next;
  status_t    status_next;

  status_t     out_status;
  logic [15:0] out_address;
  logic [7:0]  out_byte;

  assign a_adv  = a_valid && (!m_tvalid || m_tready);
  assign pop    = !empty && !clearing && (!a_valid || a_adv);
  assign stored = a_fwd ? a_fwd_byte : rd_byte;
  assign same   = (stored == a_cmd.data_byte);
  assign wr_en  = a_adv && (a_cmd.kind == CMD_LOOKUP) && !same;
  // After a lookup the stored byte equals its data, written or not, so a
  // following lookup of the same address takes that byte directly.
  assign fwd_next = a_adv && (a_cmd.kind == CMD_LOOKUP) &&
                    (a_cmd.address == head.address);

  always_comb begin
    case (a_cmd.kind)
      CMD_ADDR_FMT:  status_next = ST_ADDR_FMT;
      CMD_ADDR_HIGH: status_next = ST_ADDR_HIGH;
      CMD_BYTE_FMT:  status_next = ST_BYTE_FMT;
      CMD_LOOKUP:    status_next = same ? ST_PRESENT : ST_WRITTEN;
      default:       status_next = ST_ADDR_FMT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      byte_store[clr_idx] <= ERASED_BYTE;
    end else if (wr_en) begin
      byte_store[a_cmd.address[STORE_AW-1:0]] <= a_cmd.data_byte;
    end
    if (pop) begin
      rd_byte <= byte_store[head.address[STORE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == STORE_AW'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_cmd      <= head;
      a_fwd      <= fwd_next;
      a_fwd_byte <= a_cmd.data_byte;
    end
    if (a_adv) begin
      out_status  <= status_next;
      out_address <= a_cmd.address;
      out_byte    <= a_cmd.data_byte;
    end
  end

  assign m_tdata = {5'd0, out_byte, out_address, out_status};

endmodule

// File: hdl/hex_command_line_memory_writer.sv
// Top level of the hex command line memory writer.
// Takes one character per cycle unless the erase sweep runs or the queue is
// full. A CR or LF item passes the queue, the a stage and the output register;
// results leave up to one per cycle while m_tready is high. The queue and the
// output register let both sides stall apart. After reset an erase sweep writes
// 0xFF into all 1024 store bytes, one per cycle; s_tready is low until it ends.
`timescale 1ns / 1ps

module hex_command_line_memory_writer
  import hcmw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_char[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[2:0], address[18:3], data_byte[26:19]
);

  logic clearing;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  cmd_t head;
  logic empty;

  hcmw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .clearing   (clearing),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  hcmw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  hcmw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
